@@ src/clipped_rect_fill_and_centered_blit_top_defines.svh @@
// Assertion macros for the clipped fill and centered copy engine.
// Included by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef CLIPPED_RECT_FILL_AND_CENTERED_BLIT_TOP_DEFINES_SVH
`define CLIPPED_RECT_FILL_AND_CENTERED_BLIT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that is off while reset is asserted
`define CRFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that also holds during reset
`define CRFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CRFB_ASSERT(lbl, prop, msg)
`define CRFB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ src/crfb_pkg.sv @@
// Shared types, constants and helpers for the clipped fill and centered copy engine.
// No dependencies; used by crfb_cfg, crfb_core and the top level.
package crfb_pkg;

  // Source frame geometry
  localparam int FRAME_COLS = 640;
  localparam int FRAME_ROWS = 400;
  localparam int SRC_COL_W  = (FRAME_COLS > 1) ? $clog2(FRAME_COLS) : 1;
  localparam int SRC_ROW_W  = (FRAME_ROWS > 1) ? $clog2(FRAME_ROWS) : 1;

  // Field widths
  localparam int OP_W       = 2;
  localparam int POS_W      = 12;
  localparam int DIM_W      = 13;
  localparam int ADDR_W     = 32;
  localparam int PIX_W      = 32;
  localparam int PITCH_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = DIM_W + PITCH_W;

  // Stream packing
  localparam int IN_FIELDS_W = 2 * POS_W + 2 * DIM_W + 2 * PIX_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ADDR_W + PIX_W;

  localparam logic [DIM_W-1:0] MAX_SCREEN = DIM_W'(4096);

  // Register reset values
  localparam logic [DIM_W-1:0]   RST_SCREEN_W = DIM_W'(640);
  localparam logic [DIM_W-1:0]   RST_SCREEN_H = DIM_W'(400);
  localparam logic [PITCH_W-1:0] RST_PITCH    = PITCH_W'(2560);

  typedef enum logic [OP_W-1:0] {
    OP_SRC_PIXEL  = 2'd0,
    OP_FILL_START = 2'd1,
    OP_FILL_TICK  = 2'd2
  } crfb_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 3'd0,
    CFG_BASE   = 3'd1,
    CFG_SCR_W  = 3'd2,
    CFG_SCR_H  = 3'd3,
    CFG_PITCH  = 3'd4
  } crfb_cfg_idx_e;

  // Registered configuration plus values derived from it
  typedef struct packed {
    logic               enable;
    logic [ADDR_W-1:0]  base;
    logic [PITCH_W-1:0] pitch;
    logic [DIM_W-1:0]   scr_w;    // clamped to MAX_SCREEN
    logic [DIM_W-1:0]   scr_h;
    logic [DIM_W-1:0]   copy_w;   // min(screen, source)
    logic [DIM_W-1:0]   copy_h;
    logic [DIM_W-1:0]   x_off;    // centering offsets
    logic [DIM_W-1:0]   y_off;
  } crfb_cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] rect_x;
    logic [POS_W-1:0] rect_y;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
    logic [PIX_W-1:0] fill_colour;
    logic [PIX_W-1:0] source_pixel;
  } crfb_item_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] write_address;
    logic [PIX_W-1:0]  write_data;
    logic              last_of_run;
  } crfb_result_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    eff_dim = (d > MAX_SCREEN) ? MAX_SCREEN : d;
  endfunction

  function automatic logic [DIM_W-1:0] min_dim(input logic [DIM_W-1:0] a,
                                               input logic [DIM_W-1:0] b);
    min_dim = (a < b) ? a : b;
  endfunction

  function automatic logic [DIM_W-1:0] center_off(input logic [DIM_W-1:0] scr,
                                                  input logic [DIM_W-1:0] cpy);
    center_off = (scr > cpy) ? ((scr - cpy) >> 1) : '0;
  endfunction

endpackage

@@ src/crfb_cfg.sv @@
// Configuration register file with registered derived geometry (clamp, copy size, offsets).
// Depends on crfb_pkg.
module crfb_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [crfb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [crfb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output crfb_pkg::crfb_cfg_t             cfg_o
);
  import crfb_pkg::*;

  localparam int SrcW = FRAME_COLS;
  localparam int SrcH = FRAME_ROWS;

  logic               enable_q;
  logic [ADDR_W-1:0]  base_q;
  logic [DIM_W-1:0]   scr_w_raw_q, scr_h_raw_q;
  logic [PITCH_W-1:0] pitch_q;

  logic [DIM_W-1:0] scr_w_d, scr_h_d, copy_w_d, copy_h_d, x_off_d, y_off_d;
  logic [DIM_W-1:0] scr_w_q, scr_h_q, copy_w_q, copy_h_q, x_off_q, y_off_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      base_q      <= '0;
      scr_w_raw_q <= RST_SCREEN_W;
      scr_h_raw_q <= RST_SCREEN_H;
      pitch_q     <= RST_PITCH;
    end else if (cfg_we_i) begin
      case (crfb_cfg_idx_e'(cfg_index_i))
        CFG_ENABLE: enable_q    <= cfg_data_i[0];
        CFG_BASE:   base_q      <= cfg_data_i[ADDR_W-1:0];
        CFG_SCR_W:  scr_w_raw_q <= cfg_data_i[DIM_W-1:0];
        CFG_SCR_H:  scr_h_raw_q <= cfg_data_i[DIM_W-1:0];
        CFG_PITCH:  pitch_q     <= cfg_data_i[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived geometry, registered from the raw registers
  always_comb begin
    scr_w_d  = eff_dim(scr_w_raw_q);
    scr_h_d  = eff_dim(scr_h_raw_q);
    copy_w_d = min_dim(scr_w_d, DIM_W'(SrcW));
    copy_h_d = min_dim(scr_h_d, DIM_W'(SrcH));
    x_off_d  = center_off(scr_w_d, copy_w_d);
    y_off_d  = center_off(scr_h_d, copy_h_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q  <= eff_dim(RST_SCREEN_W);
      scr_h_q  <= eff_dim(RST_SCREEN_H);
      copy_w_q <= min_dim(eff_dim(RST_SCREEN_W), DIM_W'(SrcW));
      copy_h_q <= min_dim(eff_dim(RST_SCREEN_H), DIM_W'(SrcH));
      x_off_q  <= center_off(eff_dim(RST_SCREEN_W),
                             min_dim(eff_dim(RST_SCREEN_W), DIM_W'(SrcW)));
      y_off_q  <= center_off(eff_dim(RST_SCREEN_H),
                             min_dim(eff_dim(RST_SCREEN_H), DIM_W'(SrcH)));
    end else begin
      scr_w_q  <= scr_w_d;
      scr_h_q  <= scr_h_d;
      copy_w_q <= copy_w_d;
      copy_h_q <= copy_h_d;
      x_off_q  <= x_off_d;
      y_off_q  <= y_off_d;
    end
  end

  always_comb begin
    cfg_o.enable = enable_q;
    cfg_o.base   = base_q;
    cfg_o.pitch  = pitch_q;
    cfg_o.scr_w  = scr_w_q;
    cfg_o.scr_h  = scr_h_q;
    cfg_o.copy_w = copy_w_q;
    cfg_o.copy_h = copy_h_q;
    cfg_o.x_off  = x_off_q;
    cfg_o.y_off  = y_off_q;
  end

endmodule

@@ src/crfb_core.sv @@
// Per-item datapath: source-frame position, fill walker and pixel address generation.
// Depends on crfb_pkg and the assertion macro header.
`include "clipped_rect_fill_and_centered_blit_top_defines.svh"

module crfb_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,   // item in the input register retires
  input  crfb_pkg::crfb_item_t   item_i,
  input  crfb_pkg::crfb_cfg_t    cfg_i,
  output crfb_pkg::crfb_result_t res_o
);
  import crfb_pkg::*;

  localparam int SrcW = FRAME_COLS;
  localparam int SrcH = FRAME_ROWS;

  // Source frame position
  logic [SRC_COL_W-1:0] src_col_q, src_col_d;
  logic [SRC_ROW_W-1:0] src_row_q, src_row_d;

  // Fill walker
  logic             fill_busy_q, fill_busy_d;
  logic [POS_W-1:0] fill_left_q, fill_left_d;
  logic [POS_W-1:0] fill_col_q, fill_col_d;
  logic [POS_W-1:0] fill_row_q, fill_row_d;
  logic [DIM_W-1:0] fill_rend_q, fill_rend_d;
  logic [DIM_W-1:0] fill_bend_q, fill_bend_d;
  logic [PIX_W-1:0] fill_val_q, fill_val_d;

  crfb_op_e         op;
  logic             src_on, src_last;
  logic [DIM_W-1:0] src_c, src_r;
  logic             start_ok;
  logic [DIM_W-1:0] room_w, room_h, clip_w, clip_h;
  logic             tick_ok, col_end, fill_last;
  logic [DIM_W-1:0] col_p1, row_p1;
  logic [DIM_W-1:0] sel_col, sel_row;
  logic [PROD_W-1:0] row_off;

  assign op = crfb_op_e'(item_i.op);

  // Source pixel placement
  always_comb begin
    src_c    = DIM_W'(src_col_q);
    src_r    = DIM_W'(src_row_q);
    src_on   = cfg_i.enable && (src_c < cfg_i.scr_w) && (src_r < cfg_i.scr_h);
    src_last = ((src_c + 1'b1) == cfg_i.copy_w) && ((src_r + 1'b1) == cfg_i.copy_h);
  end

  // Fill start clipping
  always_comb begin
    start_ok = cfg_i.enable && (DIM_W'(item_i.rect_x) < cfg_i.scr_w)
               && (DIM_W'(item_i.rect_y) < cfg_i.scr_h);
    room_w   = cfg_i.scr_w - DIM_W'(item_i.rect_x);
    room_h   = cfg_i.scr_h - DIM_W'(item_i.rect_y);
    clip_w   = (item_i.rect_width > room_w) ? room_w : item_i.rect_width;
    clip_h   = (item_i.rect_height > room_h) ? room_h : item_i.rect_height;
  end

  // Fill tick position
  always_comb begin
    tick_ok   = fill_busy_q && cfg_i.enable;
    col_p1    = DIM_W'(fill_col_q) + 1'b1;
    row_p1    = DIM_W'(fill_row_q) + 1'b1;
    col_end   = col_p1 >= fill_rend_q;
    fill_last = col_end && (row_p1 >= fill_bend_q);
  end

  // Pixel address: base + row * pitch + col * 4, modulo 2^32
  always_comb begin
    if (op == OP_SRC_PIXEL) begin
      sel_col = src_c + cfg_i.x_off;
      sel_row = src_r + cfg_i.y_off;
    end else begin
      sel_col = DIM_W'(fill_col_q);
      sel_row = DIM_W'(fill_row_q);
    end
    row_off = sel_row * cfg_i.pitch;
  end

  always_comb begin
    res_o.write_address = cfg_i.base + ADDR_W'(row_off) + ADDR_W'({sel_col, 2'b00});
    res_o.valid         = 1'b0;
    res_o.write_data    = fill_val_q;
    res_o.last_of_run   = fill_last;
    case (op)
      OP_SRC_PIXEL: begin
        res_o.valid       = src_on;
        res_o.write_data  = item_i.source_pixel;
        res_o.last_of_run = src_last;
      end
      OP_FILL_TICK: res_o.valid = tick_ok;
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    src_col_d   = src_col_q;
    src_row_d   = src_row_q;
    fill_busy_d = fill_busy_q;
    fill_left_d = fill_left_q;
    fill_col_d  = fill_col_q;
    fill_row_d  = fill_row_q;
    fill_rend_d = fill_rend_q;
    fill_bend_d = fill_bend_q;
    fill_val_d  = fill_val_q;
    case (op)
      OP_SRC_PIXEL: begin
        if (src_col_q == SRC_COL_W'(SrcW - 1)) begin
          src_col_d = '0;
          src_row_d = (src_row_q == SRC_ROW_W'(SrcH - 1)) ? '0 : src_row_q + 1'b1;
        end else begin
          src_col_d = src_col_q + 1'b1;
        end
      end
      OP_FILL_START: begin
        if (start_ok && (clip_w != '0) && (clip_h != '0)) begin
          fill_busy_d = 1'b1;
          fill_left_d = item_i.rect_x;
          fill_col_d  = item_i.rect_x;
          fill_row_d  = item_i.rect_y;
          fill_rend_d = DIM_W'(item_i.rect_x) + clip_w;
          fill_bend_d = DIM_W'(item_i.rect_y) + clip_h;
          fill_val_d  = item_i.fill_colour;
        end
      end
      OP_FILL_TICK: begin
        if (tick_ok) begin
          if (fill_last) begin
            fill_busy_d = 1'b0;
          end else if (col_end) begin
            fill_col_d = fill_left_q;
            fill_row_d = fill_row_q + 1'b1;
          end else begin
            fill_col_d = fill_col_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q   <= '0;
      src_row_q   <= '0;
      fill_busy_q <= 1'b0;
    end else if (step_i) begin
      src_col_q   <= src_col_d;
      src_row_q   <= src_row_d;
      fill_busy_q <= fill_busy_d;
    end
  end

  // Fill geometry and value, only read while a fill is armed
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      fill_left_q <= fill_left_d;
      fill_col_q  <= fill_col_d;
      fill_row_q  <= fill_row_d;
      fill_rend_q <= fill_rend_d;
      fill_bend_q <= fill_bend_d;
      fill_val_q  <= fill_val_d;
    end
  end

  `CRFB_ASSERT(a_src_pos_range,
    (src_col_q <= SRC_COL_W'(SrcW - 1)) && (src_row_q <= SRC_ROW_W'(SrcH - 1)),
    "source position outside the frame")
  `CRFB_ASSERT(a_fill_inside,
    fill_busy_q |-> ((DIM_W'(fill_col_q) < fill_rend_q) && (DIM_W'(fill_row_q) < fill_bend_q)),
    "armed fill position outside its rectangle")
  `CRFB_ASSERT(a_fill_done,
    (step_i && (op == OP_FILL_TICK) && res_o.valid && res_o.last_of_run) |=> !fill_busy_q,
    "fill still armed after its last pixel")

endmodule

@@ src/clipped_rect_fill_and_centered_blit_top.sv @@
// Top level of the clipped fill and centered copy engine: input register, output register.
// Depends on crfb_pkg, crfb_cfg, crfb_core and the assertion macro header.
`include "clipped_rect_fill_and_centered_blit_top_defines.svh"

// Framebuffer write engine for 32-bit pixels. Every input beat (source pixel, fill start or
// fill tick) is registered, processed in the next cycle and, when it makes a pixel write,
// lands in the output register; one beat per clock is sustained in both directions while
// the output does not stall. Only back-pressure on the output side slows the block: the
// input register drains as long as the output register is free or being emptied. Beats
// that make no write never wait on the output. Configuration writes take effect for beats
// accepted from the cycle after the write on.
module clipped_rect_fill_and_centered_blit_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration
  input  logic                             cfg_we_i,
  input  logic [crfb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [crfb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Command stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // rect_x, rect_y, rect_width, rect_height, fill_colour, source_pixel, zero pad
  input  logic [crfb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [crfb_pkg::OP_W-1:0]        s_axis_tuser,
  // Pixel write stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // write_address, write_data
  output logic [crfb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast
);
  import crfb_pkg::*;

  crfb_cfg_t    cfg;
  crfb_item_t   in_item_q;
  crfb_result_t res;
  logic         in_valid_q, in_valid_d;
  logic         out_valid_q, out_valid_d;
  logic         out_free, retire, load_out;
  logic [ADDR_W-1:0] out_addr_q;
  logic [PIX_W-1:0]  out_data_q;
  logic              out_last_q;

  crfb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  crfb_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (retire),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Handshake: the registered beat retires unless its result has nowhere to go
  always_comb begin
    out_free      = !out_valid_q || m_axis_tready;
    retire        = in_valid_q && (!res.valid || out_free);
    load_out      = retire && res.valid;
    s_axis_tready = !in_valid_q || retire;
    in_valid_d    = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !retire);
    out_valid_d   = load_out || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register: unpack the beat
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.op           <= s_axis_tuser;
      in_item_q.rect_x       <= s_axis_tdata[POS_W-1:0];
      in_item_q.rect_y       <= s_axis_tdata[2*POS_W-1:POS_W];
      in_item_q.rect_width   <= s_axis_tdata[2*POS_W+DIM_W-1:2*POS_W];
      in_item_q.rect_height  <= s_axis_tdata[2*POS_W+2*DIM_W-1:2*POS_W+DIM_W];
      in_item_q.fill_colour  <= s_axis_tdata[2*POS_W+2*DIM_W+PIX_W-1:2*POS_W+2*DIM_W];
      in_item_q.source_pixel <= s_axis_tdata[IN_FIELDS_W-1:2*POS_W+2*DIM_W+PIX_W];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_addr_q <= res.write_address;
      out_data_q <= res.write_data;
      out_last_q <= res.last_of_run;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_data_q, out_addr_q};
  assign m_axis_tlast  = out_last_q;

  `CRFB_ASSERT(a_result_lands,
    load_out |=> m_axis_tvalid,
    "retired write missing from the output register")
  `CRFB_ASSERT(a_stall_blocks_input,
    (in_valid_q && res.valid && out_valid_q && !m_axis_tready) |-> !s_axis_tready,
    "input taken while its result is blocked")
  `CRFB_ASSERT(a_no_overwrite,
    (out_valid_q && !m_axis_tready) |-> !load_out,
    "output register overwritten while stalled")

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for clipped_rect_fill_and_centered_blit_top: a directed script and
// random phases over several screen settings, checked against a cycle-free predictor held
// here or fixed expectations. Depends on crfb_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb;
  import crfb_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int unsigned SCREEN_MAX = 4096;
  localparam int PHASE_BEATS = 100;
  localparam int IDLE_PCT = 26;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
    logic              last;
  } pixel_write_t;

  typedef enum logic [1:0] {ROW_REG, ROW_BEAT} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_WRITE} row_check_e;

  typedef struct {
    row_kind_e     kind;
    crfb_cfg_idx_e reg_idx;
    logic [31:0]   reg_val;
    crfb_item_t    beat;
    row_check_e    check;
    pixel_write_t  want;
  } script_row_t;

  // DUT inputs, all known from time zero
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [OP_W-1:0]         s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tlast;

  // Predictor copy of registers and engine state
  logic                  eng_on = 1'b0;
  logic [ADDR_W-1:0]     base_addr = '0;
  logic [DIM_W-1:0]      scr_w = RST_SCREEN_W;
  logic [DIM_W-1:0]      scr_h = RST_SCREEN_H;
  logic [PITCH_W-1:0]    pitch = RST_PITCH;
  logic [SRC_COL_W-1:0]  src_col = '0;
  logic [SRC_ROW_W-1:0]  src_row = '0;
  logic                  fill_armed = 1'b0;
  logic [POS_W-1:0]      fill_left = '0;
  logic [POS_W-1:0]      fill_col = '0;
  logic [POS_W-1:0]      fill_row = '0;
  logic [DIM_W-1:0]      fill_x_end = '0;
  logic [DIM_W-1:0]      fill_y_end = '0;
  logic [PIX_W-1:0]      fill_color = '0;

  pixel_write_t pending_writes[$];
  script_row_t  script[$];
  int           mismatches = 0;
  bit           steady = 1'b0;

  clipped_rect_fill_and_centered_blit_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Run limit, far above the slowest legal run
  initial begin
    #30_000_000;
    $display("[clipped_rect_fill_and_centered_blit_top] ERROR");
    $finish;
  end

  function automatic logic [31:0] pixel_addr(input logic [31:0] col, input logic [31:0] row);
    return base_addr + row * 32'(pitch) + col * 32'd4;
  endfunction

  // Advance the engine state by one beat; hit says whether a pixel write results
  task automatic predict_write(input crfb_item_t it, output bit hit, output pixel_write_t w);
    logic [31:0] sw, sh, cw, ch, xoff, yoff, c, r, x, y, fw, fh;
    bit done;
    sw = (32'(scr_w) > SCREEN_MAX) ? SCREEN_MAX : 32'(scr_w);
    sh = (32'(scr_h) > SCREEN_MAX) ? SCREEN_MAX : 32'(scr_h);
    hit = 1'b0;
    w = '0;
    case (it.op)
      OP_SRC_PIXEL: begin
        c = 32'(src_col);
        r = 32'(src_row);
        // source position moves even when the pixel is dropped
        if (c + 1 >= FRAME_COLS) begin
          src_col = '0;
          src_row = (r + 1 >= FRAME_ROWS) ? '0 : SRC_ROW_W'(r + 1);
        end else begin
          src_col = SRC_COL_W'(c + 1);
        end
        if (eng_on && c < sw && r < sh) begin
          cw = (sw < FRAME_COLS) ? sw : FRAME_COLS;
          ch = (sh < FRAME_ROWS) ? sh : FRAME_ROWS;
          xoff = (sw > cw) ? (sw - cw) / 2 : 0;
          yoff = (sh > ch) ? (sh - ch) / 2 : 0;
          w.addr = pixel_addr(c + xoff, r + yoff);
          w.data = it.source_pixel;
          w.last = (c + 1 == cw) && (r + 1 == ch);
          hit = 1'b1;
        end
      end
      OP_FILL_START: begin
        x = 32'(it.rect_x);
        y = 32'(it.rect_y);
        fw = 32'(it.rect_width);
        fh = 32'(it.rect_height);
        // clip to the screen; an empty result arms nothing
        if (eng_on && x < sw && y < sh) begin
          if (fw > sw - x) fw = sw - x;
          if (fh > sh - y) fh = sh - y;
          if (fw != 0 && fh != 0) begin
            fill_armed = 1'b1;
            fill_left = it.rect_x;
            fill_col = it.rect_x;
            fill_row = it.rect_y;
            fill_x_end = DIM_W'(x + fw);
            fill_y_end = DIM_W'(y + fh);
            fill_color = it.fill_colour;
          end
        end
      end
      OP_FILL_TICK: begin
        if (fill_armed && eng_on) begin
          done = (32'(fill_col) + 1 >= 32'(fill_x_end)) &&
                 (32'(fill_row) + 1 >= 32'(fill_y_end));
          w.addr = pixel_addr(32'(fill_col), 32'(fill_row));
          w.data = fill_color;
          w.last = done;
          hit = 1'b1;
          if (done) begin
            fill_armed = 1'b0;
          end else if (32'(fill_col) + 1 >= 32'(fill_x_end)) begin
            fill_col = fill_left;
            fill_row = fill_row + POS_W'(1);
          end else begin
            fill_col = fill_col + POS_W'(1);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic script_row_t reg_row(input crfb_cfg_idx_e idx, input logic [31:0] val);
    script_row_t row;
    row = '{kind: ROW_REG, reg_idx: idx, reg_val: val, beat: '0, check: CHK_NONE, want: '0};
    return row;
  endfunction

  function automatic script_row_t beat_row(
    input logic [OP_W-1:0] op, input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
    input logic [DIM_W-1:0] fw, input logic [DIM_W-1:0] fh, input logic [PIX_W-1:0] colour,
    input logic [PIX_W-1:0] pixel, input row_check_e check, input logic [ADDR_W-1:0] addr,
    input logic [PIX_W-1:0] data, input logic last);
    script_row_t row;
    row.kind = ROW_BEAT;
    row.reg_idx = CFG_ENABLE;
    row.reg_val = '0;
    row.beat = '{op: op, rect_x: x, rect_y: y, rect_width: fw, rect_height: fh,
                 fill_colour: colour, source_pixel: pixel};
    row.check = check;
    row.want = '{addr: addr, data: data, last: last};
    return row;
  endfunction

  function automatic crfb_item_t random_beat();
    crfb_item_t it;
    it.op = OP_W'($urandom_range(0, 3));
    it.rect_x = POS_W'($urandom);
    it.rect_y = POS_W'($urandom);
    it.rect_width = DIM_W'($urandom);
    it.rect_height = DIM_W'($urandom);
    it.fill_colour = $urandom;
    it.source_pixel = $urandom;
    return it;
  endfunction

  // Fill start aimed at the current screen: mostly small rectangles anywhere, some with
  // huge sizes placed near the edge so clipping keeps them short, a few off-screen
  function automatic crfb_item_t aim_fill(input crfb_item_t it);
    int unsigned sw, sh, mode;
    sw = (32'(scr_w) > SCREEN_MAX) ? SCREEN_MAX : 32'(scr_w);
    sh = (32'(scr_h) > SCREEN_MAX) ? SCREEN_MAX : 32'(scr_h);
    mode = $urandom_range(0, 99);
    it.op = OP_FILL_START;
    if (sw == 0 || sh == 0) return it;
    if (mode < 10) begin
      if (sw <= SCREEN_MAX - 1) it.rect_x = POS_W'($urandom_range(sw, SCREEN_MAX - 1));
      else if (sh <= SCREEN_MAX - 1) it.rect_y = POS_W'($urandom_range(sh, SCREEN_MAX - 1));
      else it.rect_width = '0;
    end else if (mode < 70) begin
      it.rect_x = POS_W'($urandom_range(0, sw - 1));
      it.rect_y = POS_W'($urandom_range(0, sh - 1));
      it.rect_width = DIM_W'($urandom_range(0, 6));
      it.rect_height = DIM_W'($urandom_range(0, 6));
    end else begin
      it.rect_x = POS_W'(sw - 1 - $urandom_range(0, (sw - 1 < 5) ? sw - 1 : 5));
      it.rect_y = POS_W'(sh - 1 - $urandom_range(0, (sh - 1 < 5) ? sh - 1 : 5));
    end
    return it;
  endfunction

  // Present one beat at the falling edge, with random gaps unless steady, and log its prediction
  task automatic send_beat(input crfb_item_t it, input row_check_e check,
                           input pixel_write_t want);
    bit hit;
    pixel_write_t w;
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = it.op;
    s_axis_tdata = IN_TDATA_W'({it.source_pixel, it.fill_colour, it.rect_height,
                                it.rect_width, it.rect_y, it.rect_x});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_write(it, hit, w);
    if (check == CHK_WRITE) pending_writes.push_back(want);
    else if (check == CHK_MODEL && hit) pending_writes.push_back(w);
  endtask

  // Stop sending and let the pipeline empty, including beats that make no write
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input crfb_cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    case (idx)
      CFG_ENABLE: eng_on = val[0];
      CFG_BASE:   base_addr = val;
      CFG_SCR_W:  scr_w = val[DIM_W-1:0];
      CFG_SCR_H:  scr_h = val[DIM_W-1:0];
      CFG_PITCH:  pitch = val[PITCH_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_screen(input logic en_v, input logic [31:0] base_v,
                            input int unsigned w_v, input int unsigned h_v,
                            input int unsigned pitch_v);
    wait_idle();
    write_reg(CFG_ENABLE, 32'(en_v));
    write_reg(CFG_BASE, base_v);
    write_reg(CFG_SCR_W, w_v);
    write_reg(CFG_SCR_H, h_v);
    write_reg(CFG_PITCH, pitch_v);
  endtask

  task automatic log_mismatch(input string what);
    if (mismatches < 10) $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Receiver stalls
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each accepted write beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin : check_beat
      pixel_write_t want;
      if (pending_writes.size() == 0) begin
        log_mismatch($sformatf("unexpected write addr=%h data=%h last=%0d",
                               m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast));
      end else begin
        want = pending_writes.pop_front();
        if (m_axis_tdata[31:0] !== want.addr)
          log_mismatch($sformatf("write_address exp %h got %h", want.addr, m_axis_tdata[31:0]));
        if (m_axis_tdata[63:32] !== want.data)
          log_mismatch($sformatf("write_data exp %h got %h", want.data, m_axis_tdata[63:32]));
        if (m_axis_tlast !== want.last)
          log_mismatch($sformatf("last_of_run exp %0d got %0d", want.last, m_axis_tlast));
      end
    end
  end

  initial begin
    crfb_item_t it;
    int roll;
    int count;

    // Directed script: op, x, y, width, height, colour, pixel, check, addr, data, last
    script.push_back(beat_row(OP_SRC_PIXEL, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, CHK_NONE, 0, 0, 0));
    script.push_back(beat_row(OP_FILL_START, 0, 0, 4, 2, 32'h1, 0, CHK_NONE, 0, 0, 0));
    script.push_back(beat_row(OP_FILL_TICK, 0, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0));
    script.push_back(reg_row(CFG_ENABLE, 1));
    // tick with nothing armed
    script.push_back(beat_row(OP_FILL_TICK, 0, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0));
    // off-screen starts on either axis
    script.push_back(beat_row(OP_FILL_START, 4095, 0, 8191, 1, 32'hFFFF_FFFF, 0,
                              CHK_NONE, 0, 0, 0));
    script.push_back(beat_row(OP_FILL_START, 0, 4095, 1, 1, 0, 0, CHK_NONE, 0, 0, 0));
    // zero width arms nothing
    script.push_back(beat_row(OP_FILL_START, 0, 399, 0, 5, 0, 0, CHK_NONE, 0, 0, 0));
    script.push_back(beat_row(OP_FILL_TICK, 0, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0));
    // corner start clipped down to 2x1
    script.push_back(beat_row(OP_FILL_START, 638, 399, 8191, 8191, 32'hA5A5_A5A5, 0,
                              CHK_NONE, 0, 0, 0));
    script.push_back(beat_row(OP_FILL_TICK, 0, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0));
    // new start replaces the running fill
    script.push_back(beat_row(OP_FILL_START, 0, 0, 2, 2, 32'h5A5A_5A5A, 0, CHK_NONE, 0, 0, 0));
    script.push_back(beat_row(OP_FILL_TICK, 0, 0, 0, 0, 0, 0, CHK_WRITE, 0, 32'h5A5A_5A5A, 0));
    // disabled tick leaves the fill where it was
    script.push_back(reg_row(CFG_ENABLE, 0));
    script.push_back(beat_row(OP_FILL_TICK, 0, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0));
    script.push_back(reg_row(CFG_ENABLE, 1));
    script.push_back(beat_row(OP_FILL_TICK, 0, 0, 0, 0, 0, 0, CHK_WRITE, 4, 32'h5A5A_5A5A, 0));
    script.push_back(beat_row(OP_FILL_TICK, 0, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0));
    script.push_back(beat_row(OP_FILL_TICK, 0, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0));
    script.push_back(beat_row(OP_FILL_TICK, 0, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0));
    script.push_back(beat_row(OP_RESERVED, 1, 1, 1, 1, 1, 1, CHK_NONE, 0, 0, 0));
    // source pixel at column 1, screen as large as the source
    script.push_back(beat_row(OP_SRC_PIXEL, 0, 0, 0, 0, 0, 32'h1234_5678,
                              CHK_WRITE, 4, 32'h1234_5678, 0));
    // 3x1 screen: column 2 closes the copy, column 3 is off-screen
    script.push_back(reg_row(CFG_SCR_W, 3));
    script.push_back(reg_row(CFG_SCR_H, 1));
    script.push_back(beat_row(OP_SRC_PIXEL, 0, 0, 0, 0, 0, 32'hDEAD_BEEF,
                              CHK_WRITE, 8, 32'hDEAD_BEEF, 1));
    script.push_back(beat_row(OP_SRC_PIXEL, 0, 0, 0, 0, 0, 32'h0, CHK_NONE, 0, 0, 0));
    // oversized screen clamps and centers the copy
    script.push_back(reg_row(CFG_SCR_W, 8191));
    script.push_back(reg_row(CFG_SCR_H, 4096));
    script.push_back(beat_row(OP_SRC_PIXEL, 0, 0, 0, 0, 0, 32'h0BAD_F00D, CHK_MODEL, 0, 0, 0));
    // zero-width screen: nothing lands
    script.push_back(reg_row(CFG_SCR_W, 0));
    script.push_back(beat_row(OP_FILL_START, 0, 0, 1, 1, 32'h7, 0, CHK_NONE, 0, 0, 0));
    script.push_back(beat_row(OP_SRC_PIXEL, 0, 0, 0, 0, 0, 32'h7, CHK_NONE, 0, 0, 0));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_beat(script[i].beat, script[i].check, script[i].want);
      end
    end

    // Random phases over several screen settings; phase 1 runs without any stalls
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_screen(1'b1, 32'h0, 640, 400, 2560);
        1: set_screen(1'b1, 32'hFFFF_FFFF, 4096, 4096, 65536);
        2: set_screen(1'b1, $urandom, 1, 1, 4);
        3: set_screen(1'b0, $urandom, $urandom_range(1, 4096), $urandom_range(1, 4096),
                      $urandom_range(4, 65536));
        4: set_screen(1'b1, $urandom, $urandom_range(1, 4096), $urandom_range(1, 4096),
                      $urandom_range(4, 65536));
        5: set_screen(1'b1, $urandom, $urandom_range(4097, 8191), $urandom_range(1, 600),
                      $urandom_range(4, 65536));
        default: set_screen(1'b1, $urandom, $urandom_range(1, 64), $urandom_range(1, 64),
                            $urandom_range(4, 65536));
      endcase
      steady = (ph == 1);
      count = 0;
      while (count < PHASE_BEATS) begin
        it = random_beat();
        roll = $urandom_range(0, 99);
        if (fill_armed && roll < 55) it.op = OP_FILL_TICK;
        else if (roll < 75) it.op = OP_SRC_PIXEL;
        else if (roll < 93) it = aim_fill(it);
        else if (roll < 97) it.op = OP_FILL_TICK;
        else it.op = OP_RESERVED;
        if (it.op != OP_RESERVED) count++;
        send_beat(it, CHK_MODEL, '0);
      end
    end
    steady = 1'b0;

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[clipped_rect_fill_and_centered_blit_top] OK");
    end else begin
      $display("[clipped_rect_fill_and_centered_blit_top] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/crfb_pkg.sv
src/crfb_cfg.sv
src/crfb_core.sv
src/clipped_rect_fill_and_centered_blit_top.sv
dv/tb.sv
